### rtl/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Types, hash constants and the Q0.16 lerp shared by the value noise unit.
// ----------------------------------------------------------------------------
package hvn_pkg;

    typedef logic [15:0] q16_t;
    typedef logic [31:0] word_t;

    localparam word_t HASH_MUL_X    = 32'd374761393;
    localparam word_t HASH_MUL_Y    = 32'd668265263;
    localparam word_t HASH_MUL_SEED = 32'd1442695041;
    localparam word_t HASH_MUL_MIX  = 32'd1274126177;
    localparam int unsigned HASH_SHIFT_A = 13;
    localparam int unsigned HASH_SHIFT_B = 16;

    localparam logic [17:0] SMOOTH_K0 = 18'd196608;

    function automatic q16_t lerp_q16(input q16_t a, input q16_t b, input q16_t t);
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        begin
            diff = $signed({1'b0, b}) - $signed({1'b0, a});
            prod = diff * $signed({1'b0, t});
            return q16_t'(a + prod[31:16]);
        end
    endfunction

endpackage

### rtl/hashed_value_noise_2d_unit.sv
// ----------------------------------------------------------------------------
// hashed_value_noise_2d_unit
// 2D hashed value noise: seeded lattice hash, smoothstep, bilinear blend.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per point, x_coord and y_coord in signed fixed point
//   with FRAC_BITS fraction bits. m_ channel: one word per point carrying the
//   noise value as unsigned Q0.16. cfg_we/cfg_wdata load the 32-bit seed;
//   write it only while no point is in flight.
//   Throughput is one point per cycle unless the receiver stalls with a word
//   waiting at the output. The six register stages are input capture, lattice
//   multiply, corner sum and first xorshift, mix multiply, x blend and y
//   blend; each path through a stage holds at most one multiply of up to
//   32x32 bits.
//   Reset clears all valid bits and sets the seed to zero.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hashed_value_noise_2d_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,     // seed
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // [31:0] x_coord, [63:32] y_coord
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [15:0] noise_value
);

    localparam int NUM_CORNERS = 4;

    hvn_pkg::word_t seed_mix_reg;

    logic adv;
    logic v_in_reg, v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_out_reg;

    hvn_pkg::word_t x_in_reg, y_in_reg;
    hvn_pkg::word_t x_lat, y_lat;
    hvn_pkg::q16_t  fx, fy;

    hvn_pkg::word_t px_reg, py_reg;
    hvn_pkg::word_t mix_next [NUM_CORNERS];
    hvn_pkg::word_t mix_reg  [NUM_CORNERS];
    hvn_pkg::word_t prod_c   [NUM_CORNERS];
    hvn_pkg::q16_t  corner_reg [NUM_CORNERS];

    hvn_pkg::q16_t  tx, ty;
    hvn_pkg::q16_t  lerp_a_reg, lerp_b_reg, ty_d_reg;
    hvn_pkg::q16_t  noise_reg;

    assign adv      = !v_out_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v_out_reg;
    assign m_tdata  = noise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_mix_reg <= '0;
        end else if (cfg_we) begin
            seed_mix_reg <= cfg_wdata * hvn_pkg::HASH_MUL_SEED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg  <= 1'b0;
            v_a_reg   <= 1'b0;
            v_b_reg   <= 1'b0;
            v_c_reg   <= 1'b0;
            v_d_reg   <= 1'b0;
            v_out_reg <= 1'b0;
        end else if (adv) begin
            v_in_reg  <= s_tvalid;
            v_a_reg   <= v_in_reg;
            v_b_reg   <= v_a_reg;
            v_c_reg   <= v_b_reg;
            v_d_reg   <= v_c_reg;
            v_out_reg <= v_d_reg;
        end
    end

    assign x_lat = hvn_pkg::word_t'($signed(x_in_reg) >>> FRAC_BITS);
    assign y_lat = hvn_pkg::word_t'($signed(y_in_reg) >>> FRAC_BITS);

    if (FRAC_BITS >= 16) begin : g_frac_cut
        assign fx = x_in_reg[FRAC_BITS-1 -: 16];
        assign fy = y_in_reg[FRAC_BITS-1 -: 16];
    end else begin : g_frac_pad
        assign fx = {x_in_reg[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        assign fy = {y_in_reg[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    end

    hvn_smoothstep u_smooth_x (
        .aclk  (aclk),
        .adv   (adv),
        .t_in  (fx),
        .s_out (tx)
    );

    hvn_smoothstep u_smooth_y (
        .aclk  (aclk),
        .adv   (adv),
        .t_in  (fy),
        .s_out (ty)
    );

    always_comb begin
        hvn_pkg::word_t n;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            n = px_reg + py_reg + seed_mix_reg
                + (i[0] ? hvn_pkg::HASH_MUL_X : 32'd0)
                + (i[1] ? hvn_pkg::HASH_MUL_Y : 32'd0);
            mix_next[i] = n ^ (n >> hvn_pkg::HASH_SHIFT_A);
            prod_c[i]   = mix_reg[i] * hvn_pkg::HASH_MUL_MIX;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_in_reg <= s_tdata[31:0];
            y_in_reg <= s_tdata[63:32];
            px_reg   <= x_lat * hvn_pkg::HASH_MUL_X;
            py_reg   <= y_lat * hvn_pkg::HASH_MUL_Y;
            for (int i = 0; i < NUM_CORNERS; i++) begin
                mix_reg[i]    <= mix_next[i];
                corner_reg[i] <= prod_c[i][31:16];
            end
            lerp_a_reg <= hvn_pkg::lerp_q16(corner_reg[0], corner_reg[1], tx);
            lerp_b_reg <= hvn_pkg::lerp_q16(corner_reg[2], corner_reg[3], tx);
            ty_d_reg   <= ty;
            noise_reg  <= hvn_pkg::lerp_q16(lerp_a_reg, lerp_b_reg, ty_d_reg);
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(v_d_reg) && $stable(v_in_reg)
                                     && $stable(noise_reg)))
        else $error("pipeline moved during stall");

    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_d_reg && s_tready) |=> m_tvalid)
        else $error("word lost at output stage");

endmodule

### rtl/hvn_smoothstep.sv
// ----------------------------------------------------------------------------
// hvn_smoothstep
// Three-stage pipelined smoothstep t*t*(3-2t) on a Q0.16 fraction.
// ----------------------------------------------------------------------------
module hvn_smoothstep (
    input  logic          aclk,
    input  logic          adv,
    input  hvn_pkg::q16_t t_in,
    output hvn_pkg::q16_t s_out
);

    logic [31:0]   sq_reg;
    logic [17:0]   k_reg;
    logic [49:0]   prod;
    hvn_pkg::q16_t s_next;
    hvn_pkg::q16_t s_reg;
    hvn_pkg::q16_t s_out_reg;

    always_comb begin
        prod   = sq_reg * k_reg;
        s_next = (|prod[49:48]) ? 16'hFFFF : prod[47:32];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg    <= t_in * t_in;
            k_reg     <= hvn_pkg::SMOOTH_K0 - {1'b0, t_in, 1'b0};
            s_reg     <= s_next;
            s_out_reg <= s_reg;
        end
    end

    assign s_out = s_out_reg;

endmodule
